[rtl/dirty_rect_stream_parser_top_defines.svh]
// assertion macros for the dirty rectangle stream parser
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef DIRTY_RECT_STREAM_PARSER_TOP_DEFINES_SVH
`define DIRTY_RECT_STREAM_PARSER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DRSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define DRSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DRSP_ASSERT_NOW(lbl, ante, cons, msg)
`define DRSP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/drsp_pkg.sv]
// shared constants, types and helpers of the dirty rectangle stream parser
// no dependencies
package drsp_pkg;

  localparam int COORD_BITS = 10;
  localparam int FRAME_W    = 11;
  localparam int CALC_W     = 18;
  localparam int BYTE_W     = 8;
  localparam int PIX_W      = 2 * BYTE_W;
  localparam int HDR_CNT_W  = 3;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = FRAME_W'(280);
  localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = FRAME_W'(240);

  localparam logic [BYTE_W-1:0] SYNC_A = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_B = 8'h55;
  localparam logic [1:0]        SYNC_LAST = 2'd3;
  localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(7);

  localparam logic KIND_WINDOW = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  typedef enum logic [1:0] {
    PH_SYNC    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  // frame dimension forced into 1 .. 2^COORD_BITS
  function automatic logic [CALC_W-1:0] eff_dim(input logic [FRAME_W-1:0] v);
    logic [CALC_W-1:0] lim;
    logic [CALC_W-1:0] ext;
    lim = CALC_W'(1) << COORD_BITS;
    ext = CALC_W'(v);
    if (ext == '0) begin
      eff_dim = CALC_W'(1);
    end else if (ext > lim) begin
      eff_dim = lim;
    end else begin
      eff_dim = ext;
    end
  endfunction

endpackage

[rtl/drsp_if.sv]
// valid/ready channel interfaces of the dirty rectangle stream parser
// depends on drsp_pkg
interface drsp_byte_if;
  logic                          valid;
  logic                          ready;
  logic [drsp_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface drsp_result_if;
  logic                              valid;
  logic                              ready;
  logic                              result_kind;
  logic [drsp_pkg::COORD_BITS-1:0]   win_x_start;
  logic [drsp_pkg::COORD_BITS-1:0]   win_y_start;
  logic [drsp_pkg::COORD_BITS-1:0]   win_x_end;
  logic [drsp_pkg::COORD_BITS-1:0]   win_y_end;
  logic [drsp_pkg::PIX_W-1:0]        pixel_value;
  logic                              last_pixel;

  modport source (output valid, output result_kind, output win_x_start, output win_y_start,
                  output win_x_end, output win_y_end, output pixel_value, output last_pixel,
                  input ready);
  modport sink   (input valid, input result_kind, input win_x_start, input win_y_start,
                  input win_x_end, input win_y_end, input pixel_value, input last_pixel,
                  output ready);
endinterface

interface drsp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [drsp_pkg::CFG_IDX_W-1:0]   reg_index;
  logic [drsp_pkg::FRAME_W-1:0]     wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

[rtl/dirty_rect_stream_parser_top.sv]
// dirty rectangle stream parser: sync hunt, header clamp, window and pixel items
// depends on drsp_pkg, drsp_if.sv and dirty_rect_stream_parser_top_defines.svh
//
// The parser takes one received byte per clock cycle and produces at most one
// item per byte, in the cycle after the byte is taken, from a single output
// register. A new byte is taken whenever that register is empty or is being
// read in the same cycle, so throughput is one byte per cycle as long as the
// result side keeps up; a stalled result side holds the input only when an
// unread item sits in the register. After the AA 55 AA 55 marker the eighth
// header byte yields the clamped window item, then every second payload byte
// yields an RGB565 pixel item, the final one flagged. The payload length is
// tracked by column and row counters rather than a byte count. The frame
// registers are read when a header completes; no start-up clearing pass.
`include "dirty_rect_stream_parser_top_defines.svh"

module dirty_rect_stream_parser_top (
  input  logic                  clk,
  input  logic                  rst_n,
  drsp_byte_if.sink             in_ch,
  drsp_result_if.source         out_ch,
  drsp_cfg_if.sink              cfg_ch
);

  localparam int CW = drsp_pkg::COORD_BITS;
  localparam int KW = drsp_pkg::CALC_W;
  localparam int BW = drsp_pkg::BYTE_W;

  // control state
  drsp_pkg::phase_t                   phase_r, phase_nxt;
  logic [1:0]                         sync_cnt_r, sync_cnt_nxt;
  logic [drsp_pkg::HDR_CNT_W-1:0]     hdr_cnt_r, hdr_cnt_nxt;
  logic                               low_seen_r, low_seen_nxt;
  logic [CW-1:0]                      col_r, col_nxt;
  logic [CW-1:0]                      row_r, row_nxt;
  logic [drsp_pkg::FRAME_W-1:0]       frame_width_r, frame_height_r;
  logic                               out_valid_r, out_valid_nxt;

  // payload state
  logic [BW-1:0]                      header_r [0:6];
  logic [BW-1:0]                      header_nxt [0:6];
  logic [BW-1:0]                      low_byte_r, low_byte_nxt;
  logic [CW-1:0]                      w_m1_r, w_m1_nxt;
  logic                               kind_r, kind_nxt;
  logic [CW-1:0]                      x_start_r, x_start_nxt;
  logic [CW-1:0]                      y_start_r, y_start_nxt;
  logic [CW-1:0]                      x_end_r, x_end_nxt;
  logic [CW-1:0]                      y_end_r, y_end_nxt;
  logic [drsp_pkg::PIX_W-1:0]         pixel_r, pixel_nxt;
  logic                               last_r, last_nxt;

  logic                               in_fire;
  logic                               emit;
  logic [BW-1:0]                      rx;

  // header clamp
  logic [KW-1:0] fw, fh;
  logic [KW-1:0] x_raw, y_raw, w_raw, h_raw;
  logic [KW-1:0] x_c, y_c, w_nz, h_nz, w_c, h_c, x_e, y_e;

  assign rx           = in_ch.rx_byte;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    fw    = drsp_pkg::eff_dim(frame_width_r);
    fh    = drsp_pkg::eff_dim(frame_height_r);
    x_raw = KW'({header_r[1], header_r[0]});
    y_raw = KW'({header_r[3], header_r[2]});
    w_raw = KW'({header_r[5], header_r[4]});
    h_raw = KW'({rx, header_r[6]});
    x_c   = (x_raw >= fw) ? '0 : x_raw;
    y_c   = (y_raw >= fh) ? '0 : y_raw;
    w_nz  = (w_raw == '0) ? KW'(1) : w_raw;
    h_nz  = (h_raw == '0) ? KW'(1) : h_raw;
    w_c   = (x_c + w_nz > fw) ? fw - x_c : w_nz;
    h_c   = (y_c + h_nz > fh) ? fh - y_c : h_nz;
    x_e   = x_c + w_c - KW'(1);
    y_e   = y_c + h_c - KW'(1);
  end

  always_comb begin
    phase_nxt    = phase_r;
    sync_cnt_nxt = sync_cnt_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    low_seen_nxt = low_seen_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    w_m1_nxt     = w_m1_r;
    low_byte_nxt = low_byte_r;
    for (int i = 0; i < 7; i++) begin
      header_nxt[i] = header_r[i];
    end
    emit         = 1'b0;
    kind_nxt     = kind_r;
    x_start_nxt  = x_start_r;
    y_start_nxt  = y_start_r;
    x_end_nxt    = x_end_r;
    y_end_nxt    = y_end_r;
    pixel_nxt    = pixel_r;
    last_nxt     = last_r;

    if (in_fire) begin
      case (phase_r)
        drsp_pkg::PH_HEADER: begin
          if (hdr_cnt_r == drsp_pkg::HDR_LAST) begin
            emit         = 1'b1;
            kind_nxt     = drsp_pkg::KIND_WINDOW;
            x_start_nxt  = x_c[CW-1:0];
            y_start_nxt  = y_c[CW-1:0];
            x_end_nxt    = x_e[CW-1:0];
            y_end_nxt    = y_e[CW-1:0];
            pixel_nxt    = '0;
            last_nxt     = 1'b0;
            w_m1_nxt     = CW'(w_c - KW'(1));
            col_nxt      = CW'(w_c - KW'(1));
            row_nxt      = CW'(h_c - KW'(1));
            low_seen_nxt = 1'b0;
            hdr_cnt_nxt  = '0;
            phase_nxt    = drsp_pkg::PH_PAYLOAD;
          end else begin
            header_nxt[hdr_cnt_r] = rx;
            hdr_cnt_nxt           = hdr_cnt_r + 1'b1;
          end
        end
        drsp_pkg::PH_PAYLOAD: begin
          if (!low_seen_r) begin
            low_byte_nxt = rx;
            low_seen_nxt = 1'b1;
          end else begin
            emit         = 1'b1;
            low_seen_nxt = 1'b0;
            kind_nxt     = drsp_pkg::KIND_PIXEL;
            x_start_nxt  = '0;
            y_start_nxt  = '0;
            x_end_nxt    = '0;
            y_end_nxt    = '0;
            pixel_nxt    = {rx, low_byte_r};
            last_nxt     = (col_r == '0) && (row_r == '0);
            if ((col_r == '0) && (row_r == '0)) begin
              phase_nxt    = drsp_pkg::PH_SYNC;
              sync_cnt_nxt = '0;
            end else if (col_r == '0) begin
              col_nxt = w_m1_r;
              row_nxt = row_r - 1'b1;
            end else begin
              col_nxt = col_r - 1'b1;
            end
          end
        end
        default: begin
          phase_nxt = drsp_pkg::PH_SYNC;
          if (rx == (sync_cnt_r[0] ? drsp_pkg::SYNC_B : drsp_pkg::SYNC_A)) begin
            if (sync_cnt_r == drsp_pkg::SYNC_LAST) begin
              sync_cnt_nxt = '0;
              hdr_cnt_nxt  = '0;
              phase_nxt    = drsp_pkg::PH_HEADER;
            end else begin
              sync_cnt_nxt = sync_cnt_r + 1'b1;
            end
          end else begin
            sync_cnt_nxt = (rx == drsp_pkg::SYNC_A) ? 2'd1 : 2'd0;
          end
        end
      endcase
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= drsp_pkg::PH_SYNC;
      sync_cnt_r     <= '0;
      hdr_cnt_r      <= '0;
      low_seen_r     <= 1'b0;
      col_r          <= '0;
      row_r          <= '0;
      out_valid_r    <= 1'b0;
      frame_width_r  <= drsp_pkg::FRAME_WIDTH_RST;
      frame_height_r <= drsp_pkg::FRAME_HEIGHT_RST;
    end else begin
      phase_r     <= phase_nxt;
      sync_cnt_r  <= sync_cnt_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      low_seen_r  <= low_seen_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && (cfg_ch.reg_index == drsp_pkg::REG_FRAME_WIDTH)) begin
        frame_width_r <= cfg_ch.wr_data;
      end
      if (cfg_ch.valid && (cfg_ch.reg_index == drsp_pkg::REG_FRAME_HEIGHT)) begin
        frame_height_r <= cfg_ch.wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 7; i++) begin
      header_r[i] <= header_nxt[i];
    end
    low_byte_r <= low_byte_nxt;
    w_m1_r     <= w_m1_nxt;
    kind_r     <= kind_nxt;
    x_start_r  <= x_start_nxt;
    y_start_r  <= y_start_nxt;
    x_end_r    <= x_end_nxt;
    y_end_r    <= y_end_nxt;
    pixel_r    <= pixel_nxt;
    last_r     <= last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_kind = kind_r;
  assign out_ch.win_x_start = x_start_r;
  assign out_ch.win_y_start = y_start_r;
  assign out_ch.win_x_end   = x_end_r;
  assign out_ch.win_y_end   = y_end_r;
  assign out_ch.pixel_value = pixel_r;
  assign out_ch.last_pixel  = last_r;

  `DRSP_ASSERT_NOW(a_win_order, out_valid_r && (kind_r == drsp_pkg::KIND_WINDOW), (x_start_r <= x_end_r) && (y_start_r <= y_end_r), "window end before start")
  `DRSP_ASSERT_NOW(a_win_no_pixel, out_valid_r && (kind_r == drsp_pkg::KIND_WINDOW), (pixel_r == '0) && !last_r, "window item carries pixel data")
  `DRSP_ASSERT_NOW(a_sync_idle, phase_r != drsp_pkg::PH_SYNC, sync_cnt_r == '0, "sync count kept outside hunting")
  `DRSP_ASSERT_NEXT(a_last_rehunt, in_fire && (phase_r == drsp_pkg::PH_PAYLOAD) && low_seen_r && (col_r == '0) && (row_r == '0), (phase_r == drsp_pkg::PH_SYNC) && out_valid_r && last_r, "last pixel did not end the frame")

endmodule

[dv/testbench.sv]
// testbench for dirty_rect_stream_parser_top: byte stream in, window and pixel items out
// depends on drsp_pkg, drsp_if.sv and the parser rtl
// random idling on both channels, predicted items checked in order
module testbench;
  import drsp_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_PIXELS = 24;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

  typedef struct packed {
    logic kind;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    logic [PIX_W-1:0] pixel;
    logic last;
  } rect_item_t;

  logic clk = 1'b0;
  logic rst_n;

  drsp_byte_if in_if();
  drsp_result_if out_if();
  drsp_cfg_if cfg_if();

  dirty_rect_stream_parser_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [BYTE_W-1:0] byte_q[$];
  rect_item_t due_items[$];
  int pushed = 0;
  int bytes_taken = 0;
  int results_seen = 0;
  int error_count = 0;
  int quiet_cycles = 0;
  bit in_held = 1'b0;
  bit idle_on = 1'b1;
  bit hold_off = 1'b0;

  // parser state as predicted
  logic [FRAME_W-1:0] fw_reg = FRAME_WIDTH_RST;
  logic [FRAME_W-1:0] fh_reg = FRAME_HEIGHT_RST;
  phase_t ph = PH_SYNC;
  int sync_cnt = 0;
  logic [BYTE_W-1:0] hdr[8];
  int hdr_cnt = 0;
  int bytes_left = 0;
  logic [BYTE_W-1:0] low_hold = '0;

  function automatic logic [BYTE_W-1:0] sync_byte(input int i);
    return i[0] ? SYNC_B : SYNC_A;
  endfunction

  function automatic void clamp_rect(input logic [FRAME_W-1:0] fwr, input logic [FRAME_W-1:0] fhr,
                                     input int x, input int y, input int w, input int h,
                                     output int xs, output int ys, output int wc, output int hc);
    int fw;
    int fh;
    fw = (fwr == 0) ? 1 : (int'(fwr) > (1 << COORD_BITS)) ? (1 << COORD_BITS) : int'(fwr);
    fh = (fhr == 0) ? 1 : (int'(fhr) > (1 << COORD_BITS)) ? (1 << COORD_BITS) : int'(fhr);
    xs = (x >= fw) ? 0 : x;
    ys = (y >= fh) ? 0 : y;
    wc = (w == 0) ? 1 : w;
    hc = (h == 0) ? 1 : h;
    if (xs + wc > fw) wc = fw - xs;
    if (ys + hc > fh) hc = fh - ys;
  endfunction

  task automatic parse_rx_byte(input logic [BYTE_W-1:0] b);
    rect_item_t it;
    int xs;
    int ys;
    int wc;
    int hc;
    bit even;
    it = '0;
    case (ph)
      PH_HEADER: begin
        hdr[hdr_cnt] = b;
        hdr_cnt++;
        if (hdr_cnt == 8) begin
          clamp_rect(fw_reg, fh_reg, int'({hdr[1], hdr[0]}), int'({hdr[3], hdr[2]}),
                     int'({hdr[5], hdr[4]}), int'({hdr[7], hdr[6]}), xs, ys, wc, hc);
          bytes_left = 2 * wc * hc;
          ph = PH_PAYLOAD;
          it.kind = KIND_WINDOW;
          it.x_start = COORD_BITS'(xs);
          it.y_start = COORD_BITS'(ys);
          it.x_end = COORD_BITS'(xs + wc - 1);
          it.y_end = COORD_BITS'(ys + hc - 1);
          due_items.push_back(it);
        end
      end
      PH_PAYLOAD: begin
        even = (bytes_left % 2 == 0);
        if (bytes_left > 0) bytes_left--;
        if (bytes_left == 0) begin
          ph = PH_SYNC;
          sync_cnt = 0;
        end
        if (even && bytes_left != 0) begin
          low_hold = b;
        end else begin
          it.kind = KIND_PIXEL;
          it.pixel = {b, low_hold};
          it.last = (bytes_left == 0);
          due_items.push_back(it);
        end
      end
      default: begin
        ph = PH_SYNC;
        if (b == sync_byte(sync_cnt)) begin
          sync_cnt++;
          if (sync_cnt == 4) begin
            ph = PH_HEADER;
            hdr_cnt = 0;
            sync_cnt = 0;
          end
        end else begin
          sync_cnt = (b == SYNC_A) ? 1 : 0;
        end
      end
    endcase
  endtask

  task automatic report_error(input string msg);
    error_count++;
    $display("ERROR at item %0d: %s", results_seen, msg);
  endtask

  task automatic compare_field(input string name, input logic [PIX_W-1:0] want,
                               input logic [PIX_W-1:0] seen);
    if (seen !== want) report_error($sformatf("%s expected 0x%0h got 0x%0h", name, want, seen));
  endtask

  // input side: prediction on acceptance
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      parse_rx_byte(in_if.rx_byte);
      void'(byte_q.pop_front());
      bytes_taken++;
    end
    in_held = rst_n && in_if.valid && !in_if.ready;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_held) begin
      if (byte_q.size() != 0 && !(idle_on && $urandom_range(99) < 37)) begin
        in_if.valid <= 1'b1;
        in_if.rx_byte <= byte_q[0];
      end else begin
        in_if.valid <= 1'b0;
        in_if.rx_byte <= BYTE_W'($urandom);
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !hold_off && !(idle_on && $urandom_range(99) < 37);
    end
  end

  always @(posedge clk) begin
    rect_item_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (due_items.size() == 0) begin
        report_error($sformatf("unexpected item, kind %0d", out_if.result_kind));
      end else begin
        want = due_items.pop_front();
        compare_field("result_kind", PIX_W'(want.kind), PIX_W'(out_if.result_kind));
        compare_field("win_x_start", PIX_W'(want.x_start), PIX_W'(out_if.win_x_start));
        compare_field("win_y_start", PIX_W'(want.y_start), PIX_W'(out_if.win_y_start));
        compare_field("win_x_end", PIX_W'(want.x_end), PIX_W'(out_if.win_x_end));
        compare_field("win_y_end", PIX_W'(want.y_end), PIX_W'(out_if.win_y_end));
        compare_field("pixel_value", want.pixel, out_if.pixel_value);
        compare_field("last_pixel", PIX_W'(want.last), PIX_W'(out_if.last_pixel));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst_n && ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                  (cfg_if.valid && cfg_if.ready))) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // long output stall while the input keeps offering
  initial begin
    while (bytes_taken < 400 || byte_q.size() < 100) @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    byte_q.push_back(b);
    pushed++;
  endtask

  task automatic push_u16(input int v);
    push_byte(BYTE_W'(v));
    push_byte(BYTE_W'(v >> 8));
  endtask

  task automatic push_marker();
    for (int i = 0; i < 4; i++) push_byte(sync_byte(i));
  endtask

  task automatic add_frame(input int x, input int y, input int w, input int h);
    int xs;
    int ys;
    int wc;
    int hc;
    clamp_rect(fw_reg, fh_reg, x, y, w, h, xs, ys, wc, hc);
    push_marker();
    push_u16(x);
    push_u16(y);
    push_u16(w);
    push_u16(h);
    repeat (2 * wc * hc) push_byte(BYTE_W'($urandom));
  endtask

  function automatic int pick_pos(input logic [FRAME_W-1:0] lim);
    int v;
    case ($urandom_range(3))
      0: v = int'($urandom_range(16'hFFFF));
      1: v = int'(lim) - 1 - int'($urandom_range(3));
      2: v = int'($urandom_range(7));
      default: v = int'($urandom_range(int'(lim)));
    endcase
    return (v < 0) ? 0 : v;
  endfunction

  function automatic int pick_len();
    case ($urandom_range(3))
      0: return 0;
      1: return int'($urandom_range(16'hFFFF));
      default: return int'($urandom_range(1, 5));
    endcase
  endfunction

  task automatic add_random_frames(input int budget);
    int start;
    int x;
    int y;
    int w;
    int h;
    int xs;
    int ys;
    int wc;
    int hc;
    int k;
    logic [BYTE_W-1:0] b;
    start = pushed;
    while (pushed - start < budget) begin
      case ($urandom_range(7))
        0, 1: begin
          repeat ($urandom_range(1, 6)) push_byte(BYTE_W'($urandom));
          push_byte(8'h00);
        end
        2: begin
          // marker cut short by a wrong byte
          k = $urandom_range(1, 3);
          for (int i = 0; i < k; i++) push_byte(sync_byte(i));
          do b = BYTE_W'($urandom); while (b == sync_byte(k));
          push_byte(b);
        end
        default: ;
      endcase
      if ($urandom_range(3) == 0) push_byte(SYNC_A);
      do begin
        x = pick_pos(fw_reg);
        y = pick_pos(fh_reg);
        w = pick_len();
        h = pick_len();
        clamp_rect(fw_reg, fh_reg, x, y, w, h, xs, ys, wc, hc);
      end while (wc * hc > MAX_PIXELS);
      add_frame(x, y, w, h);
    end
  endtask

  task automatic settle();
    while (byte_q.size() != 0 || due_items.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FRAME_W-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wr_data <= val;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == REG_FRAME_WIDTH) fw_reg = val;
    else if (idx == REG_FRAME_HEIGHT) fh_reg = val;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic retune(input logic [FRAME_W-1:0] w, input logic [FRAME_W-1:0] h);
    settle();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.rx_byte = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.reg_index = '0;
    cfg_if.wr_data = '0;

    // restart on a repeated AA, then a zero-size header grown to one pixel
    push_byte(SYNC_A);
    push_marker();
    push_u16(0);
    push_u16(0);
    push_u16(0);
    push_u16(0);
    push_byte(8'hFF);
    push_byte(8'h00);
    // x on the last column with a width cut to fit, y past the edge
    push_marker();
    push_u16(279);
    push_u16('hFFFF);
    push_u16('hFFFF);
    push_u16(1);
    push_byte(8'h00);
    push_byte(8'hFF);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_random_frames(200);
    retune(FRAME_W'(1), FRAME_W'(1));
    add_random_frames(150);
    idle_on = 1'b0;
    retune(FRAME_W'(0), FRAME_W'(2047));
    add_random_frames(200);
    idle_on = 1'b1;
    retune(FRAME_W'(1024), FRAME_W'(1024));
    add_frame(1020, 5, 'hFFFF, 1);
    add_random_frames(250);
    settle();
    write_reg(REG_UNUSED, FRAME_W'($urandom));
    retune(FRAME_W'(2047), FRAME_W'(0));
    add_random_frames(200);
    retune(FRAME_W'($urandom_range(2047)), FRAME_W'($urandom_range(2047)));
    add_random_frames(250);
    retune(FRAME_W'($urandom_range(1, 64)), FRAME_W'($urandom_range(1, 64)));
    add_random_frames(250);

    settle();
    repeat (8) @(posedge clk);
    if (error_count == 0 && due_items.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
